/* rtl/dpec_pkg.sv */
// Shared widths, item types and saturation helper for the disk pair collision block.
`timescale 1ns / 1ps
package dpec_pkg;

  localparam int POS_W     = 32;
  localparam int RAD_W     = 24;
  localparam int MASS_W    = 16;
  localparam int DIST_W    = 25;
  localparam int DX_W      = 26;
  localparam int DEN_W     = 25;
  localparam int NUM_W     = 64;
  localparam int SQ_W      = 52;
  localparam int TT_W      = 50;
  localparam int ROOT_W    = 26;
  localparam int SQ_STEPS  = SQ_W / 2;
  localparam int REM_W     = ROOT_W + 4;
  localparam int DIV_STEPS = NUM_W;
  localparam int PR_W      = POS_W + 1 + DX_W;
  localparam int REL_W     = PR_W + 1;
  localparam int OV_W      = DIST_W + 1;
  localparam int PO_W      = OV_W + DX_W;
  localparam int UN_W      = 37;
  localparam int MS_W      = MASS_W + 1;
  localparam int MJ_W      = MS_W + 1 + UN_W;
  localparam int PX_W      = 28;
  localparam int PB_W      = RAD_W + 1 + PX_W;
  localparam int J_W       = UN_W + 1;
  localparam int QW        = 56;
  localparam int SUM_W     = QW + 2;
  localparam int Q_DEPTH   = 4;
  localparam int PTR_W     = $clog2(Q_DEPTH);
  localparam int QCNT_W    = $clog2(Q_DEPTH + 1);

  // classified pair as it leaves the front
  typedef struct packed {
    logic signed [POS_W-1:0] a_pos_x;
    logic signed [POS_W-1:0] a_pos_y;
    logic signed [POS_W-1:0] a_vel_x;
    logic signed [POS_W-1:0] a_vel_y;
    logic signed [POS_W-1:0] b_pos_x;
    logic signed [POS_W-1:0] b_pos_y;
    logic signed [POS_W-1:0] b_vel_x;
    logic signed [POS_W-1:0] b_vel_y;
    logic [RAD_W-1:0]        ar;
    logic [RAD_W-1:0]        br;
    logic [MASS_W-1:0]       am;
    logic [MASS_W-1:0]       bm;
    logic signed [DX_W-1:0]  dx;
    logic signed [DX_W-1:0]  dy;
    logic [DIST_W-1:0]       t;
    logic                    near;
  } fe_t;

  // context carried down the back pipeline
  typedef struct packed {
    fe_t                   fe;
    logic                  hit;
    logic [DIST_W-1:0]     d;
    logic signed [QW-1:0]  qa_x;
    logic signed [QW-1:0]  qa_y;
    logic signed [QW-1:0]  qb_x;
    logic signed [QW-1:0]  qb_y;
  } ctx_t;

  function automatic logic signed [POS_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [POS_W-1:0] res;
    if (v[SUM_W-1:POS_W-1] == '0 || v[SUM_W-1:POS_W-1] == '1) begin
      res = v[POS_W-1:0];
    end else if (v[SUM_W-1]) begin
      res = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(POS_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

/* rtl/dpec_if.sv */
// Valid/ready channel interfaces for disk pairs and collision results.
`timescale 1ns / 1ps
interface dpec_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [dpec_pkg::POS_W-1:0] a_pos_x;
  logic signed [dpec_pkg::POS_W-1:0] a_pos_y;
  logic signed [dpec_pkg::POS_W-1:0] a_vel_x;
  logic signed [dpec_pkg::POS_W-1:0] a_vel_y;
  logic [dpec_pkg::RAD_W-1:0]        a_radius;
  logic [dpec_pkg::MASS_W-1:0]       a_mass;
  logic signed [dpec_pkg::POS_W-1:0] b_pos_x;
  logic signed [dpec_pkg::POS_W-1:0] b_pos_y;
  logic signed [dpec_pkg::POS_W-1:0] b_vel_x;
  logic signed [dpec_pkg::POS_W-1:0] b_vel_y;
  logic [dpec_pkg::RAD_W-1:0]        b_radius;
  logic [dpec_pkg::MASS_W-1:0]       b_mass;

  modport source (output valid, a_pos_x, a_pos_y, a_vel_x, a_vel_y, a_radius, a_mass,
                  b_pos_x, b_pos_y, b_vel_x, b_vel_y, b_radius, b_mass, input ready);
  modport sink (input valid, a_pos_x, a_pos_y, a_vel_x, a_vel_y, a_radius, a_mass,
                b_pos_x, b_pos_y, b_vel_x, b_vel_y, b_radius, b_mass, output ready);
endinterface

interface dpec_out_if;
  logic                             valid;
  logic                             ready;
  logic                             hit;
  logic [dpec_pkg::DIST_W-1:0]       center_dist;
  logic signed [dpec_pkg::POS_W-1:0] a_new_x;
  logic signed [dpec_pkg::POS_W-1:0] a_new_y;
  logic signed [dpec_pkg::POS_W-1:0] a_new_vx;
  logic signed [dpec_pkg::POS_W-1:0] a_new_vy;
  logic signed [dpec_pkg::POS_W-1:0] b_new_x;
  logic signed [dpec_pkg::POS_W-1:0] b_new_y;
  logic signed [dpec_pkg::POS_W-1:0] b_new_vx;
  logic signed [dpec_pkg::POS_W-1:0] b_new_vy;

  modport source (output valid, hit, center_dist, a_new_x, a_new_y, a_new_vx, a_new_vy,
                  b_new_x, b_new_y, b_new_vx, b_new_vy, input ready);
  modport sink (input valid, hit, center_dist, a_new_x, a_new_y, a_new_vx, a_new_vy,
                b_new_x, b_new_y, b_new_vx, b_new_vy, output ready);
endinterface

/* rtl/dpec_front.sv */
// Front: takes pairs, classifies them by axis distance and queues them for the back.
`timescale 1ns / 1ps
module dpec_front (
  input  logic            clk,
  input  logic            rst_n,
  dpec_in_if.sink         in_ch,
  input  logic            pop,
  output logic            q_vld,
  output dpec_pkg::fe_t   q_head
);
  import dpec_pkg::*;

  logic signed [POS_W:0] dx_w;
  logic signed [POS_W:0] dy_w;
  logic [POS_W:0]        adx;
  logic [POS_W:0]        ady;
  logic [DIST_W-1:0]     t_sum;
  logic                  near;
  logic                  push;
  fe_t                   ent;

  fe_t                   q_mem_r [Q_DEPTH];
  logic [PTR_W-1:0]      wr_r;
  logic [PTR_W-1:0]      rd_r;
  logic [QCNT_W-1:0]     cnt_r;
  logic [QCNT_W-1:0]     cnt_nxt;

  always_comb begin
    dx_w  = (POS_W+1)'(in_ch.b_pos_x) - (POS_W+1)'(in_ch.a_pos_x);
    dy_w  = (POS_W+1)'(in_ch.b_pos_y) - (POS_W+1)'(in_ch.a_pos_y);
    adx   = dx_w[POS_W] ? $unsigned(-dx_w) : $unsigned(dx_w);
    ady   = dy_w[POS_W] ? $unsigned(-dy_w) : $unsigned(dy_w);
    t_sum = DIST_W'(in_ch.a_radius) + DIST_W'(in_ch.b_radius);
    near  = (adx <= (POS_W+1)'(t_sum)) && (ady <= (POS_W+1)'(t_sum));

    ent.a_pos_x = in_ch.a_pos_x;
    ent.a_pos_y = in_ch.a_pos_y;
    ent.a_vel_x = in_ch.a_vel_x;
    ent.a_vel_y = in_ch.a_vel_y;
    ent.b_pos_x = in_ch.b_pos_x;
    ent.b_pos_y = in_ch.b_pos_y;
    ent.b_vel_x = in_ch.b_vel_x;
    ent.b_vel_y = in_ch.b_vel_y;
    ent.ar      = in_ch.a_radius;
    ent.br      = in_ch.b_radius;
    // a zero mass counts as one
    ent.am      = (in_ch.a_mass == '0) ? MASS_W'(1) : in_ch.a_mass;
    ent.bm      = (in_ch.b_mass == '0) ? MASS_W'(1) : in_ch.b_mass;
    // far pairs never square; zero the offsets so the back stays in range
    ent.dx      = near ? dx_w[DX_W-1:0] : '0;
    ent.dy      = near ? dy_w[DX_W-1:0] : '0;
    ent.t       = t_sum;
    ent.near    = near;
  end

  assign in_ch.ready = (cnt_r != QCNT_W'(Q_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_vld       = (cnt_r != '0);
  assign q_head      = q_mem_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_r] <= ent;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0)
    else $error("queue popped while empty");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(Q_DEPTH))
    else $error("queue count above depth");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    PTR_W'(wr_r - rd_r) == cnt_r[PTR_W-1:0])
    else $error("queue pointers disagree with count");

endmodule

/* rtl/dpec_sqrt.sv */
// Pipelined integer square root, two radicand bits per stage, context carried alongside.
`timescale 1ns / 1ps
module dpec_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [dpec_pkg::SQ_W-1:0]  s,
  input  dpec_pkg::ctx_t             in_ctx,
  output logic                       out_vld,
  output logic [dpec_pkg::ROOT_W-1:0] root,
  output dpec_pkg::ctx_t             out_ctx
);
  import dpec_pkg::*;

  logic [REM_W-1:0]  rem_r    [SQ_STEPS];
  logic [ROOT_W-1:0] root_r   [SQ_STEPS];
  logic [SQ_W-1:0]   sr_r     [SQ_STEPS];
  logic              vld_r    [SQ_STEPS];
  ctx_t              ctx_r    [SQ_STEPS];

  logic [REM_W-1:0]  rin      [SQ_STEPS];
  logic [ROOT_W-1:0] oin      [SQ_STEPS];
  logic [SQ_W-1:0]   sin      [SQ_STEPS];
  logic [REM_W-1:0]  cur      [SQ_STEPS];
  logic [REM_W-1:0]  trial    [SQ_STEPS];
  logic              ge       [SQ_STEPS];
  logic [REM_W-1:0]  rem_nxt  [SQ_STEPS];
  logic [ROOT_W-1:0] root_nxt [SQ_STEPS];
  logic [SQ_W-1:0]   sr_nxt   [SQ_STEPS];

  always_comb begin
    for (int i = 0; i < SQ_STEPS; i++) begin
      if (i == 0) begin
        rin[i] = '0;
        oin[i] = '0;
        sin[i] = s;
      end else begin
        rin[i] = rem_r[i-1];
        oin[i] = root_r[i-1];
        sin[i] = sr_r[i-1];
      end
      // bring down the next two radicand bits and try root*4+1
      cur[i]      = {rin[i][REM_W-3:0], sin[i][SQ_W-1 -: 2]};
      trial[i]    = REM_W'({oin[i], 2'b01});
      ge[i]       = (cur[i] >= trial[i]);
      rem_nxt[i]  = ge[i] ? (cur[i] - trial[i]) : cur[i];
      root_nxt[i] = {oin[i][ROOT_W-2:0], ge[i]};
      sr_nxt[i]   = {sin[i][SQ_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SQ_STEPS; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      for (int i = 0; i < SQ_STEPS; i++) begin
        vld_r[i] <= (i == 0) ? in_vld : vld_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < SQ_STEPS; i++) begin
        rem_r[i]  <= rem_nxt[i];
        root_r[i] <= root_nxt[i];
        sr_r[i]   <= sr_nxt[i];
        ctx_r[i]  <= (i == 0) ? in_ctx : ctx_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  assign out_vld = vld_r[SQ_STEPS-1];
  assign root    = root_r[SQ_STEPS-1];
  assign out_ctx = ctx_r[SQ_STEPS-1];

endmodule

/* rtl/dpec_div.sv */
// Pipelined signed divider, one quotient bit per stage, quotient rounded half away from zero.
`timescale 1ns / 1ps
module dpec_div (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [dpec_pkg::NUM_W-1:0] num,
  input  logic [dpec_pkg::DEN_W-1:0]        den,
  output logic signed [dpec_pkg::NUM_W-1:0] quo
);
  import dpec_pkg::*;

  logic [DEN_W-1:0] rem_r   [DIV_STEPS];
  logic [NUM_W-1:0] acc_r   [DIV_STEPS];
  logic [DEN_W-1:0] den_r   [DIV_STEPS];
  logic             neg_r   [DIV_STEPS];

  logic [NUM_W-1:0] mag;
  logic [DEN_W-1:0] rin     [DIV_STEPS];
  logic [NUM_W-1:0] ain     [DIV_STEPS];
  logic [DEN_W-1:0] din     [DIV_STEPS];
  logic             nin     [DIV_STEPS];
  logic [DEN_W:0]   trial   [DIV_STEPS];
  logic             ge      [DIV_STEPS];
  logic [DEN_W-1:0] rem_nxt [DIV_STEPS];
  logic [NUM_W-1:0] acc_nxt [DIV_STEPS];

  // add half the divisor up front so truncation rounds to nearest
  assign mag = num[NUM_W-1] ? $unsigned(-num) : $unsigned(num);

  always_comb begin
    for (int i = 0; i < DIV_STEPS; i++) begin
      if (i == 0) begin
        rin[i] = '0;
        ain[i] = mag + NUM_W'(den >> 1);
        din[i] = den;
        nin[i] = num[NUM_W-1];
      end else begin
        rin[i] = rem_r[i-1];
        ain[i] = acc_r[i-1];
        din[i] = den_r[i-1];
        nin[i] = neg_r[i-1];
      end
      trial[i]   = {rin[i], ain[i][NUM_W-1]};
      ge[i]      = (trial[i] >= {1'b0, din[i]});
      rem_nxt[i] = ge[i] ? DEN_W'(trial[i] - {1'b0, din[i]}) : trial[i][DEN_W-1:0];
      acc_nxt[i] = {ain[i][NUM_W-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < DIV_STEPS; i++) begin
        rem_r[i] <= rem_nxt[i];
        acc_r[i] <= acc_nxt[i];
        den_r[i] <= din[i];
        neg_r[i] <= nin[i];
      end
    end
  end

  assign quo = neg_r[DIV_STEPS-1] ? -$signed(acc_r[DIV_STEPS-1])
                                  : $signed(acc_r[DIV_STEPS-1]);

endmodule

/* rtl/dpec_dly.sv */
// Valid and context delay line matching the divider latency.
`timescale 1ns / 1ps
module dpec_dly (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  dpec_pkg::ctx_t in_ctx,
  output logic           out_vld,
  output dpec_pkg::ctx_t out_ctx
);
  import dpec_pkg::*;

  logic vld_r [DIV_STEPS];
  ctx_t ctx_r [DIV_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_STEPS; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int i = 1; i < DIV_STEPS; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_r[0] <= in_ctx;
      for (int i = 1; i < DIV_STEPS; i++) begin
        ctx_r[i] <= ctx_r[i-1];
      end
    end
  end

  assign out_vld = vld_r[DIV_STEPS-1];
  assign out_ctx = ctx_r[DIV_STEPS-1];

endmodule

/* rtl/dpec_back.sv */
// Back: distance, normal impulse and separation pipeline, ending in the result register.
`timescale 1ns / 1ps
module dpec_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_vld,
  input  dpec_pkg::fe_t  q_head,
  output logic           pop,
  dpec_out_if.source     out_ch
);
  import dpec_pkg::*;

  logic adv;

  // S0: squares
  logic                    s0_vld_r;
  ctx_t                    s0_ctx_r;
  logic signed [SQ_W-1:0]  s0_sqx_r;
  logic signed [SQ_W-1:0]  s0_sqy_r;
  logic [TT_W-1:0]         s0_tt_r;
  ctx_t                    s0_ctx_nxt;

  // S1: sum and hit test
  logic                    s1_vld_r;
  ctx_t                    s1_ctx_r;
  logic [SQ_W-1:0]         s1_s_r;
  logic [SQ_W-1:0]         s_sum;
  ctx_t                    s1_ctx_nxt;

  // root
  logic                    sq_vld;
  logic [ROOT_W-1:0]       sq_root;
  ctx_t                    sq_ctx;

  // S2: relative velocity products, overlap
  logic                    s2_vld_r;
  ctx_t                    s2_ctx_r;
  logic signed [PR_W-1:0]  s2_prx_r;
  logic signed [PR_W-1:0]  s2_pry_r;
  logic signed [OV_W-1:0]  s2_ov_r;
  ctx_t                    s2_ctx_nxt;
  logic signed [POS_W:0]   dvx;
  logic signed [POS_W:0]   dvy;

  // S3: dot product, overlap products
  logic                    s3_vld_r;
  ctx_t                    s3_ctx_r;
  logic signed [REL_W-1:0] s3_rel_r;
  logic signed [PO_W-1:0]  s3_pox_r;
  logic signed [PO_W-1:0]  s3_poy_r;

  logic                    d1_vld;
  ctx_t                    d1_ctx;
  logic signed [NUM_W-1:0] q_un;
  logic signed [NUM_W-1:0] q_px;
  logic signed [NUM_W-1:0] q_py;

  // S4: impulse numerators, push numerators
  logic                    s4_vld_r;
  ctx_t                    s4_ctx_r;
  logic signed [MJ_W-1:0]  s4_mb2_r;
  logic signed [MJ_W-1:0]  s4_ma2_r;
  logic [MS_W-1:0]         s4_m_r;
  logic signed [PB_W-1:0]  s4_pbx_r;
  logic signed [PB_W-1:0]  s4_pby_r;
  logic signed [PB_W-1:0]  s4_pax_r;
  logic signed [PB_W-1:0]  s4_pay_r;
  logic signed [UN_W-1:0]  un;
  logic signed [PX_W-1:0]  px;
  logic signed [PX_W-1:0]  py;

  logic                    d2_vld;
  ctx_t                    d2_ctx;
  logic signed [NUM_W-1:0] q_ja;
  logic signed [NUM_W-1:0] q_jb;
  logic signed [NUM_W-1:0] q_qax;
  logic signed [NUM_W-1:0] q_qay;
  logic signed [NUM_W-1:0] q_qbx;
  logic signed [NUM_W-1:0] q_qby;

  // S5: impulse along the normal
  logic                    s5_vld_r;
  ctx_t                    s5_ctx_r;
  logic signed [NUM_W-1:0] s5_vax_r;
  logic signed [NUM_W-1:0] s5_vay_r;
  logic signed [NUM_W-1:0] s5_vbx_r;
  logic signed [NUM_W-1:0] s5_vby_r;
  logic signed [J_W-1:0]   ja;
  logic signed [J_W-1:0]   jb;
  ctx_t                    s5_ctx_nxt;

  logic                    d3_vld;
  ctx_t                    d3_ctx;
  logic signed [NUM_W-1:0] q_vax;
  logic signed [NUM_W-1:0] q_vay;
  logic signed [NUM_W-1:0] q_vbx;
  logic signed [NUM_W-1:0] q_vby;

  // result register
  logic                    out_valid_r;
  logic                    hit_r;
  logic [DIST_W-1:0]       center_dist_r;
  logic signed [POS_W-1:0] a_new_x_r;
  logic signed [POS_W-1:0] a_new_y_r;
  logic signed [POS_W-1:0] a_new_vx_r;
  logic signed [POS_W-1:0] a_new_vy_r;
  logic signed [POS_W-1:0] b_new_x_r;
  logic signed [POS_W-1:0] b_new_y_r;
  logic signed [POS_W-1:0] b_new_vx_r;
  logic signed [POS_W-1:0] b_new_vy_r;

  // the whole back advances together; it holds only while a result waits
  assign adv = !out_valid_r || out_ch.ready;
  assign pop = adv && q_vld;

  always_comb begin
    s0_ctx_nxt    = '0;
    s0_ctx_nxt.fe = q_head;

    s_sum         = $unsigned(s0_sqx_r) + $unsigned(s0_sqy_r);
    s1_ctx_nxt    = s0_ctx_r;
    s1_ctx_nxt.hit = s0_ctx_r.fe.near && (s_sum != '0) && (s_sum < SQ_W'(s0_tt_r));

    s2_ctx_nxt    = sq_ctx;
    s2_ctx_nxt.d  = sq_root[DIST_W-1:0];
    dvx = (POS_W+1)'(sq_ctx.fe.b_vel_x) - (POS_W+1)'(sq_ctx.fe.a_vel_x);
    dvy = (POS_W+1)'(sq_ctx.fe.b_vel_y) - (POS_W+1)'(sq_ctx.fe.a_vel_y);

    un = q_un[UN_W-1:0];
    px = q_px[PX_W-1:0];
    py = q_py[PX_W-1:0];

    ja = q_ja[J_W-1:0];
    jb = q_jb[J_W-1:0];
    s5_ctx_nxt      = d2_ctx;
    s5_ctx_nxt.qa_x = q_qax[QW-1:0];
    s5_ctx_nxt.qa_y = q_qay[QW-1:0];
    s5_ctx_nxt.qb_x = q_qbx[QW-1:0];
    s5_ctx_nxt.qb_y = q_qby[QW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r    <= 1'b0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      s4_vld_r    <= 1'b0;
      s5_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r    <= q_vld;
      s1_vld_r    <= s0_vld_r;
      s2_vld_r    <= sq_vld;
      s3_vld_r    <= s2_vld_r;
      s4_vld_r    <= d1_vld;
      s5_vld_r    <= d2_vld;
      out_valid_r <= d3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_ctx_r <= s0_ctx_nxt;
      s0_sqx_r <= q_head.dx * q_head.dx;
      s0_sqy_r <= q_head.dy * q_head.dy;
      s0_tt_r  <= q_head.t * q_head.t;

      s1_ctx_r <= s1_ctx_nxt;
      s1_s_r   <= s_sum;

      s2_ctx_r <= s2_ctx_nxt;
      s2_prx_r <= dvx * sq_ctx.fe.dx;
      s2_pry_r <= dvy * sq_ctx.fe.dy;
      s2_ov_r  <= $signed({1'b0, sq_ctx.fe.t}) - $signed({1'b0, sq_root[DIST_W-1:0]});

      s3_ctx_r <= s2_ctx_r;
      s3_rel_r <= REL_W'(s2_prx_r) + REL_W'(s2_pry_r);
      s3_pox_r <= s2_ov_r * s2_ctx_r.fe.dx;
      s3_poy_r <= s2_ov_r * s2_ctx_r.fe.dy;

      s4_ctx_r <= d1_ctx;
      s4_mb2_r <= $signed({1'b0, d1_ctx.fe.bm, 1'b0}) * un;
      s4_ma2_r <= $signed({1'b0, d1_ctx.fe.am, 1'b0}) * un;
      s4_m_r   <= MS_W'(d1_ctx.fe.am) + MS_W'(d1_ctx.fe.bm);
      s4_pbx_r <= $signed({1'b0, d1_ctx.fe.br}) * px;
      s4_pby_r <= $signed({1'b0, d1_ctx.fe.br}) * py;
      s4_pax_r <= $signed({1'b0, d1_ctx.fe.ar}) * px;
      s4_pay_r <= $signed({1'b0, d1_ctx.fe.ar}) * py;

      s5_ctx_r <= s5_ctx_nxt;
      s5_vax_r <= ja * d2_ctx.fe.dx;
      s5_vay_r <= ja * d2_ctx.fe.dy;
      s5_vbx_r <= jb * d2_ctx.fe.dx;
      s5_vby_r <= jb * d2_ctx.fe.dy;

      hit_r <= d3_ctx.hit;
      if (d3_ctx.hit) begin
        center_dist_r <= d3_ctx.d;
        a_new_x_r  <= sat32(SUM_W'(d3_ctx.fe.a_pos_x) - SUM_W'(d3_ctx.qa_x));
        a_new_y_r  <= sat32(SUM_W'(d3_ctx.fe.a_pos_y) - SUM_W'(d3_ctx.qa_y));
        a_new_vx_r <= sat32(SUM_W'(d3_ctx.fe.a_vel_x) + SUM_W'($signed(q_vax[QW-1:0])));
        a_new_vy_r <= sat32(SUM_W'(d3_ctx.fe.a_vel_y) + SUM_W'($signed(q_vay[QW-1:0])));
        b_new_x_r  <= sat32(SUM_W'(d3_ctx.fe.b_pos_x) + SUM_W'(d3_ctx.qb_x));
        b_new_y_r  <= sat32(SUM_W'(d3_ctx.fe.b_pos_y) + SUM_W'(d3_ctx.qb_y));
        b_new_vx_r <= sat32(SUM_W'(d3_ctx.fe.b_vel_x) - SUM_W'($signed(q_vbx[QW-1:0])));
        b_new_vy_r <= sat32(SUM_W'(d3_ctx.fe.b_vel_y) - SUM_W'($signed(q_vby[QW-1:0])));
      end else begin
        // no contact: pass the pair through untouched
        center_dist_r <= '0;
        a_new_x_r  <= d3_ctx.fe.a_pos_x;
        a_new_y_r  <= d3_ctx.fe.a_pos_y;
        a_new_vx_r <= d3_ctx.fe.a_vel_x;
        a_new_vy_r <= d3_ctx.fe.a_vel_y;
        b_new_x_r  <= d3_ctx.fe.b_pos_x;
        b_new_y_r  <= d3_ctx.fe.b_pos_y;
        b_new_vx_r <= d3_ctx.fe.b_vel_x;
        b_new_vy_r <= d3_ctx.fe.b_vel_y;
      end
    end
  end

  dpec_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_vld(s1_vld_r), .s(s1_s_r), .in_ctx(s1_ctx_r),
    .out_vld(sq_vld), .root(sq_root), .out_ctx(sq_ctx)
  );

  // first divide level: normal speed and unit push per axis
  dpec_dly u_dly1 (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_vld(s3_vld_r), .in_ctx(s3_ctx_r),
    .out_vld(d1_vld), .out_ctx(d1_ctx)
  );
  dpec_div u_div_un (.clk(clk), .en(adv), .num(NUM_W'(s3_rel_r)), .den(s3_ctx_r.d), .quo(q_un));
  dpec_div u_div_px (.clk(clk), .en(adv), .num(NUM_W'(s3_pox_r)), .den(s3_ctx_r.d), .quo(q_px));
  dpec_div u_div_py (.clk(clk), .en(adv), .num(NUM_W'(s3_poy_r)), .den(s3_ctx_r.d), .quo(q_py));

  // second level: mass-weighted impulses and position pushes
  dpec_dly u_dly2 (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_vld(s4_vld_r), .in_ctx(s4_ctx_r),
    .out_vld(d2_vld), .out_ctx(d2_ctx)
  );
  dpec_div u_div_ja (.clk(clk), .en(adv), .num(NUM_W'(s4_mb2_r)), .den(DEN_W'(s4_m_r)),
                     .quo(q_ja));
  dpec_div u_div_jb (.clk(clk), .en(adv), .num(NUM_W'(s4_ma2_r)), .den(DEN_W'(s4_m_r)),
                     .quo(q_jb));
  dpec_div u_div_qax (.clk(clk), .en(adv), .num(NUM_W'(s4_pbx_r)), .den(s4_ctx_r.d),
                      .quo(q_qax));
  dpec_div u_div_qay (.clk(clk), .en(adv), .num(NUM_W'(s4_pby_r)), .den(s4_ctx_r.d),
                      .quo(q_qay));
  dpec_div u_div_qbx (.clk(clk), .en(adv), .num(NUM_W'(s4_pax_r)), .den(s4_ctx_r.d),
                      .quo(q_qbx));
  dpec_div u_div_qby (.clk(clk), .en(adv), .num(NUM_W'(s4_pay_r)), .den(s4_ctx_r.d),
                      .quo(q_qby));

  // third level: velocity changes per axis
  dpec_dly u_dly3 (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_vld(s5_vld_r), .in_ctx(s5_ctx_r),
    .out_vld(d3_vld), .out_ctx(d3_ctx)
  );
  dpec_div u_div_vax (.clk(clk), .en(adv), .num(s5_vax_r), .den(s5_ctx_r.d), .quo(q_vax));
  dpec_div u_div_vay (.clk(clk), .en(adv), .num(s5_vay_r), .den(s5_ctx_r.d), .quo(q_vay));
  dpec_div u_div_vbx (.clk(clk), .en(adv), .num(s5_vbx_r), .den(s5_ctx_r.d), .quo(q_vbx));
  dpec_div u_div_vby (.clk(clk), .en(adv), .num(s5_vby_r), .den(s5_ctx_r.d), .quo(q_vby));

  assign out_ch.valid       = out_valid_r;
  assign out_ch.hit         = hit_r;
  assign out_ch.center_dist = center_dist_r;
  assign out_ch.a_new_x     = a_new_x_r;
  assign out_ch.a_new_y     = a_new_y_r;
  assign out_ch.a_new_vx    = a_new_vx_r;
  assign out_ch.a_new_vy    = a_new_vy_r;
  assign out_ch.b_new_x     = b_new_x_r;
  assign out_ch.b_new_y     = b_new_y_r;
  assign out_ch.b_new_vx    = b_new_vx_r;
  assign out_ch.b_new_vy    = b_new_vy_r;

  a_hit_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && hit_r |-> center_dist_r != '0)
    else $error("hit reported with zero distance");

  a_miss_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !hit_r |-> center_dist_r == '0)
    else $error("miss reported with nonzero distance");

  a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> $stable(s5_vld_r) && $stable(s0_vld_r))
    else $error("pipeline moved while result held");

endmodule

/* rtl/disk_pair_elastic_collision.sv */
// Top level of the two-disk elastic collision unit: front queue and arithmetic back.
//
//  channel  | dir | handshake          | payload
//  in_ch    | in  | valid/ready        | two disks: position, velocity, radius, mass
//  out_ch   | out | valid/ready        | hit, center_dist, new positions and velocities
//
// One pair enters per cycle while the queue has room; each result passes through the root
// pipeline (26 stages) and three chained 64-stage divider levels.
// Reset clears the queue and every stage valid bit; no memory needs clearing.
// A held result freezes the back; the four-entry queue keeps taking pairs until full.
`timescale 1ns / 1ps
module disk_pair_elastic_collision (
  input  logic        clk,
  input  logic        rst_n,
  dpec_in_if.sink     in_ch,
  dpec_out_if.source  out_ch
);
  import dpec_pkg::*;

  logic q_vld;
  logic pop;
  fe_t  q_head;

  dpec_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .pop(pop), .q_vld(q_vld), .q_head(q_head)
  );

  dpec_back u_back (
    .clk(clk), .rst_n(rst_n), .q_vld(q_vld), .q_head(q_head), .pop(pop), .out_ch(out_ch)
  );

endmodule

/* verif/disk_pair_elastic_collision_test.sv */
// Self-checking bench for the disk pair collision unit: random traffic, scoreboard compare.
`timescale 1ns / 1ps
module disk_pair_elastic_collision_test;
  import dpec_pkg::*;

  typedef struct {
    logic signed [POS_W-1:0] a_pos_x, a_pos_y, a_vel_x, a_vel_y;
    logic [RAD_W-1:0]        a_radius;
    logic [MASS_W-1:0]       a_mass;
    logic signed [POS_W-1:0] b_pos_x, b_pos_y, b_vel_x, b_vel_y;
    logic [RAD_W-1:0]        b_radius;
    logic [MASS_W-1:0]       b_mass;
  } pair_t;

  typedef struct {
    logic                    hit;
    logic [DIST_W-1:0]       center_dist;
    logic signed [POS_W-1:0] a_new_x, a_new_y, a_new_vx, a_new_vy;
    logic signed [POS_W-1:0] b_new_x, b_new_y, b_new_vx, b_new_vy;
  } bounce_t;

  class bounce_board;
    bounce_t pending_bounces[$];
    int      errors = 0;

    function longint rnd_div(longint num, longint den);
      longint unsigned mag, q;
      mag = num < 0 ? 64'd0 - num : num;
      q = (mag + den / 2) / den;
      return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    function longint unsigned root(longint unsigned s);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b >>= 2;
      while (b != 0) begin
        if (s >= r + b) begin
          s -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function logic signed [POS_W-1:0] clamp(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[POS_W-1:0];
    endfunction

    // predict the bounce of one accepted pair
    function void note(pair_t p);
      bounce_t e;
      longint ax, ay, avx, avy, bx, by, bvx, bvy, ar, br, am, bm;
      longint t, dx, dy, adx, ady, d, un, ms, ja, jb, ov, px, py;
      longint unsigned s;
      ax = p.a_pos_x; ay = p.a_pos_y; avx = p.a_vel_x; avy = p.a_vel_y;
      bx = p.b_pos_x; by = p.b_pos_y; bvx = p.b_vel_x; bvy = p.b_vel_y;
      ar = p.a_radius; br = p.b_radius;
      am = p.a_mass == 0 ? 1 : p.a_mass;
      bm = p.b_mass == 0 ? 1 : p.b_mass;
      t = ar + br;
      dx = bx - ax;
      dy = by - ay;
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      e.hit = 0;
      d = 0;
      if (adx <= t && ady <= t) begin
        s = adx * adx + ady * ady;
        if (s > 0 && s < t * t) begin
          e.hit = 1;
          d = root(s);
        end
      end
      e.center_dist = e.hit ? d[DIST_W-1:0] : '0;
      if (!e.hit) begin
        e.a_new_x = p.a_pos_x; e.a_new_y = p.a_pos_y;
        e.a_new_vx = p.a_vel_x; e.a_new_vy = p.a_vel_y;
        e.b_new_x = p.b_pos_x; e.b_new_y = p.b_pos_y;
        e.b_new_vx = p.b_vel_x; e.b_new_vy = p.b_vel_y;
      end else begin
        un = rnd_div((bvx - avx) * dx + (bvy - avy) * dy, d);
        ms = am + bm;
        ja = rnd_div(2 * bm * un, ms);
        jb = rnd_div(2 * am * un, ms);
        ov = t - d;
        px = rnd_div(ov * dx, d);
        py = rnd_div(ov * dy, d);
        e.a_new_x = clamp(ax - rnd_div(br * px, d));
        e.a_new_y = clamp(ay - rnd_div(br * py, d));
        e.a_new_vx = clamp(avx + rnd_div(ja * dx, d));
        e.a_new_vy = clamp(avy + rnd_div(ja * dy, d));
        e.b_new_x = clamp(bx + rnd_div(ar * px, d));
        e.b_new_y = clamp(by + rnd_div(ar * py, d));
        e.b_new_vx = clamp(bvx - rnd_div(jb * dx, d));
        e.b_new_vy = clamp(bvy - rnd_div(jb * dy, d));
      end
      pending_bounces.push_back(e);
    endfunction

    function void cmp(string name, longint e, longint a);
      if (e != a) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
      end
    endfunction

    function void check(bounce_t a);
      bounce_t e;
      if (pending_bounces.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, got hit %0b dist %0d", $time, a.hit,
                 a.center_dist);
        return;
      end
      e = pending_bounces.pop_front();
      cmp("hit", e.hit, a.hit);
      cmp("center_dist", e.center_dist, a.center_dist);
      cmp("a_new_x", e.a_new_x, a.a_new_x);
      cmp("a_new_y", e.a_new_y, a.a_new_y);
      cmp("a_new_vx", e.a_new_vx, a.a_new_vx);
      cmp("a_new_vy", e.a_new_vy, a.a_new_vy);
      cmp("b_new_x", e.b_new_x, a.b_new_x);
      cmp("b_new_y", e.b_new_y, a.b_new_y);
      cmp("b_new_vx", e.b_new_vx, a.b_new_vx);
      cmp("b_new_vy", e.b_new_vy, a.b_new_vy);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  dpec_in_if  in_ch();
  dpec_out_if out_ch();

  disk_pair_elastic_collision dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  bounce_board board = new();
  bit          in_took = 0;
  bit          long_hold_req = 0;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    pair_t   p;
    bounce_t r;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        p.a_pos_x = in_ch.a_pos_x; p.a_pos_y = in_ch.a_pos_y;
        p.a_vel_x = in_ch.a_vel_x; p.a_vel_y = in_ch.a_vel_y;
        p.a_radius = in_ch.a_radius; p.a_mass = in_ch.a_mass;
        p.b_pos_x = in_ch.b_pos_x; p.b_pos_y = in_ch.b_pos_y;
        p.b_vel_x = in_ch.b_vel_x; p.b_vel_y = in_ch.b_vel_y;
        p.b_radius = in_ch.b_radius; p.b_mass = in_ch.b_mass;
        board.note(p);
        in_took = 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        r.hit = out_ch.hit; r.center_dist = out_ch.center_dist;
        r.a_new_x = out_ch.a_new_x; r.a_new_y = out_ch.a_new_y;
        r.a_new_vx = out_ch.a_new_vx; r.a_new_vy = out_ch.a_new_vy;
        r.b_new_x = out_ch.b_new_x; r.b_new_y = out_ch.b_new_y;
        r.b_new_vx = out_ch.b_new_vx; r.b_new_vy = out_ch.b_new_vy;
        board.check(r);
      end
    end
  end

  // result side: random ready with varying density, rare long stalls
  initial begin
    int stall_left;
    int density;
    int span;
    stall_left = 0;
    density = 100;
    span = 0;
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 0;
        stall_left = 700;
      end
      if (span == 0) begin
        span = $urandom_range(50, 300);
        case ($urandom_range(0, 3))
          0: density = 100;
          1: density = 80;
          2: density = 50;
          default: density = 20;
        endcase
      end
      span--;
      if (stall_left == 0 && $urandom_range(0, 399) == 0) stall_left = $urandom_range(20, 90);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 0;
      end else begin
        out_ch.ready <= ($urandom_range(1, 100) <= density);
      end
    end
  end

  function automatic longint spread(int unsigned m);
    return longint'($urandom_range(0, 2 * m)) - longint'(m);
  endfunction

  function automatic pair_t random_pair();
    pair_t       p;
    int unsigned kind, t;
    longint      ox, oy;
    kind = $urandom_range(0, 99);
    p.a_pos_x = $urandom; p.a_pos_y = $urandom;
    p.b_pos_x = $urandom; p.b_pos_y = $urandom;
    p.a_vel_x = $urandom; p.a_vel_y = $urandom;
    p.b_vel_x = $urandom; p.b_vel_y = $urandom;
    p.a_radius = RAD_W'($urandom); p.b_radius = RAD_W'($urandom);
    p.a_mass = MASS_W'($urandom_range(1, 65535)); p.b_mass = MASS_W'($urandom_range(1, 65535));
    if (kind < 12) return p;
    if ($urandom_range(0, 3) != 0) begin
      p.a_radius = RAD_W'($urandom_range(1, 1 << 20));
      p.b_radius = RAD_W'($urandom_range(1, 1 << 20));
    end
    if ($urandom_range(0, 1) == 0) begin
      p.a_vel_x = POS_W'(spread(1 << 20)); p.a_vel_y = POS_W'(spread(1 << 20));
      p.b_vel_x = POS_W'(spread(1 << 20)); p.b_vel_y = POS_W'(spread(1 << 20));
    end
    if ($urandom_range(0, 4) == 0) begin
      p.a_mass = MASS_W'($urandom_range(1, 4));
      p.b_mass = MASS_W'($urandom_range(1, 65535));
    end
    // pull toward the rails so the separation saturates
    if ($urandom_range(0, 9) == 0) begin
      p.a_pos_x = $urandom_range(0, 1) ? 32'sh7FFF_F000 : 32'sh8000_0FFF;
      p.a_pos_y = $urandom_range(0, 1) ? 32'sh7FFF_F000 : 32'sh8000_0FFF;
    end
    t = p.a_radius + p.b_radius;
    if (kind < 20) begin
      // touching or coincident
      ox = $urandom_range(0, 1) ? 0 : ($urandom_range(0, 1) ? t : -longint'(t));
      oy = 0;
    end else begin
      ox = spread(t);
      oy = spread(t);
    end
    p.b_pos_x = POS_W'(p.a_pos_x + ox);
    p.b_pos_y = POS_W'(p.a_pos_y + oy);
    return p;
  endfunction

  task automatic send_pair(pair_t p, int gap);
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_ch.a_pos_x <= p.a_pos_x; in_ch.a_pos_y <= p.a_pos_y;
    in_ch.a_vel_x <= p.a_vel_x; in_ch.a_vel_y <= p.a_vel_y;
    in_ch.a_radius <= p.a_radius; in_ch.a_mass <= p.a_mass;
    in_ch.b_pos_x <= p.b_pos_x; in_ch.b_pos_y <= p.b_pos_y;
    in_ch.b_vel_x <= p.b_vel_x; in_ch.b_vel_y <= p.b_vel_y;
    in_ch.b_radius <= p.b_radius; in_ch.b_mass <= p.b_mass;
    in_ch.valid <= 1;
    do @(negedge clk); while (!in_took);
    in_took = 0;
  endtask

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 96) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  task automatic drain();
    in_ch.valid <= 0;
    while (board.pending_bounces.size() != 0) @(negedge clk);
  endtask

  function automatic pair_t make_pair(longint ax, longint ay, longint avx, longint avy,
                                      int unsigned ar, int unsigned am, longint bx,
                                      longint by, longint bvx, longint bvy,
                                      int unsigned br, int unsigned bm);
    pair_t p;
    p.a_pos_x = POS_W'(ax); p.a_pos_y = POS_W'(ay);
    p.a_vel_x = POS_W'(avx); p.a_vel_y = POS_W'(avy);
    p.a_radius = RAD_W'(ar); p.a_mass = MASS_W'(am);
    p.b_pos_x = POS_W'(bx); p.b_pos_y = POS_W'(by);
    p.b_vel_x = POS_W'(bvx); p.b_vel_y = POS_W'(bvy);
    p.b_radius = RAD_W'(br); p.b_mass = MASS_W'(bm);
    return p;
  endfunction

  initial begin
    pair_t  directed[$];
    longint mx, mn;
    int     k;
    mx = 64'sd2147483647;
    mn = -64'sd2147483648;
    rst_n = 0;
    in_ch.valid = 0;
    in_ch.a_pos_x = 0; in_ch.a_pos_y = 0; in_ch.a_vel_x = 0; in_ch.a_vel_y = 0;
    in_ch.a_radius = 0; in_ch.a_mass = 1;
    in_ch.b_pos_x = 0; in_ch.b_pos_y = 0; in_ch.b_vel_x = 0; in_ch.b_vel_y = 0;
    in_ch.b_radius = 0; in_ch.b_mass = 1;
    repeat (9) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // coincident centers, zero radii, zero masses
    directed.push_back(make_pair(0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 1));
    directed.push_back(make_pair(5, 7, 1, 2, 65536, 3, 5, 7, 9, 9, 65536, 4));
    directed.push_back(make_pair(0, 0, 65536, 0, 65536, 0, 65536, 0, -65536, 0, 65536, 0));
    // positions, radii and masses at their top, then positions at their bottom
    directed.push_back(make_pair(mx, mx, mx, mx, 24'hFFFFFF, 16'hFFFF,
                                 mx, mx - 1, mn, mn, 24'hFFFFFF, 16'hFFFF));
    directed.push_back(make_pair(mn, mn, mn, mn, 24'hFFFFFF, 1,
                                 mn + 1, mn, mx, mx, 24'hFFFFFF, 1));
    // far apart on either axis: widest possible gap, then just out of reach
    directed.push_back(make_pair(mn, 0, 1, 1, 24'hFFFFFF, 9, mx, 0, 2, 2, 24'hFFFFFF, 9));
    directed.push_back(make_pair(0, 0, 1, 1, 100, 9, 0, 201, 2, 2, 100, 9));
    // exactly touching: no hit; one LSB closer: a hit
    directed.push_back(make_pair(0, 0, 1, 1, 100, 9, 200, 0, 2, 2, 100, 9));
    directed.push_back(make_pair(0, 0, 1, 1, 100, 9, 199, 0, -2, 2, 100, 9));
    // one LSB apart with huge radii: largest pushes, saturating positions
    directed.push_back(make_pair(mx, mx, mx, mn, 24'hFFFFFF, 1, mx - 1, mx, mn, mx,
                                 24'hFFFFFF, 65535));
    directed.push_back(make_pair(mn, mn, mn, mx, 24'hFFFFFF, 65535, mn + 1, mn + 1, mx, mn,
                                 24'hFFFFFF, 1));
    directed.push_back(make_pair(0, 0, mx, mx, 24'hFFFFFF, 1, 1, 1, mn, mn, 24'hFFFFFF, 1));
    // head-on and glancing hits
    directed.push_back(make_pair(0, 0, 65536, 0, 65536, 1, 65536, 0, -65536, 0, 65536, 1));
    directed.push_back(make_pair(0, 0, 65536, 30000, 65536, 2, 40000, 90000, 0, -5000,
                                 65536, 7));
    directed.push_back(make_pair(-300, 800, -1, 0, 500, 65535, 200, -100, 3, 77, 700, 1));
    foreach (directed[i]) send_pair(directed[i], pick_gap());
    drain();

    // fill the block while the result side holds off
    long_hold_req = 1;
    for (k = 0; k < 300; k++) send_pair(random_pair(), 0);

    for (k = 0; k < 1640; k++) begin
      send_pair(random_pair(), pick_gap());
      if (k == 800) drain();
    end
    drain();
    repeat (300) @(negedge clk);
    if (board.errors == 0 && board.pending_bounces.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
